[design/ccrse_pkg.sv]
// shared types and constants for the clipped cell raster span emitter
package ccrse_pkg;

    // configuration port
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_X      = 3'd0,
        CFG_DEST_Y      = 3'd1,
        CFG_CLIP_LEFT   = 3'd2,
        CFG_CLIP_TOP    = 3'd3,
        CFG_CLIP_WIDTH  = 3'd4,
        CFG_CLIP_HEIGHT = 3'd5,
        CFG_TRANSPARENT = 3'd6,
        CFG_PEN_MAP     = 3'd7
    } cfg_idx_t;

    // field widths
    localparam int CODE_W  = 4;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 8;
    localparam int POS_W   = 8;
    localparam int LEN_W   = 8;
    localparam int PEN_W   = 4;
    localparam int TCODE_W = 5;

    // reset values of the registers
    localparam logic [POS_W-1:0]   CLIP_SIZE_RST      = 8'd255;
    localparam logic [TCODE_W-1:0] TRANSPARENT_NONE   = 5'd16;

    // cells at or beyond this column are always dropped
    localparam int MAX_WIDTH = 128;

    // codes below this one go through the pen map
    localparam logic [CODE_W-1:0]  PEN_MAPPED_LIMIT   = 4'd4;

    // depth of the span queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // one screen span
    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [LEN_W-1:0] len;
        logic [PEN_W-1:0] pen;
    } span_t;

    // one queue entry: the spans caused by one cell, one or two of them
    typedef struct packed {
        logic  two;
        span_t s0;
        span_t s1;
    } qent_t;

    // push request from front to queue
    typedef struct packed {
        logic  push;
        qent_t ent;
    } qpush_t;

endpackage

[design/ccrse_if.sv]
// request channels for raster cells and screen spans
interface cell_if;
    logic       valid;
    logic       ready;
    logic [3:0] cell_code;
    logic [6:0] cell_col;
    logic [7:0] cell_row;
    logic       row_end;

    modport source (output valid, cell_code, cell_col, cell_row, row_end, input ready);
    modport sink   (input valid, cell_code, cell_col, cell_row, row_end, output ready);
endinterface

interface span_if;
    logic       valid;
    logic       ready;
    logic [7:0] span_x;
    logic [7:0] span_y;
    logic [7:0] span_len;
    logic [3:0] span_pen;
    logic       last_of_item;

    modport source (output valid, span_x, span_y, span_len, span_pen, last_of_item,
                    input ready);
    modport sink   (input valid, span_x, span_y, span_len, span_pen, last_of_item,
                    output ready);
endinterface

[design/ccrse_queue.sv]
// span queue between the front classifier and the back emitter
module ccrse_queue
    import ccrse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   clk,
    input  logic   rst_n,
    input  qpush_t wr,
    input  logic   pop,
    output logic   full,
    output logic   nonempty,
    output qent_t  head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    qent_t         ent_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = ent_reg[rd_ptr_reg];
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && nonempty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= wr.ent;
        end
    end

endmodule

[design/ccrse_front.sv]
// front end: configuration registers, clipping, run tracking and span forming
module ccrse_front
    import ccrse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    cell_if.sink                  cells,
    input  logic                  q_full,
    output qpush_t                qwr
);

    // configuration registers
    logic [POS_W-1:0]      dest_x_reg, dest_y_reg;
    logic [POS_W-1:0]      clip_left_reg, clip_top_reg;
    logic [POS_W-1:0]      clip_width_reg, clip_height_reg;
    logic [TCODE_W-1:0]    tcode_reg;
    logic [CFG_DATA_W-1:0] pen_map_reg;

    // open run
    logic             run_open_reg, run_open_next;
    logic [COL_W-1:0] run_start_reg, run_start_next;
    logic [PEN_W-1:0] run_pen_reg, run_pen_next;
    logic [LEN_W-1:0] run_len_reg, run_len_next;
    logic [ROW_W-1:0] run_row_reg, run_row_next;

    logic             accept;
    logic [POS_W:0]   sx, sy, clip_r, clip_b;
    logic             visible, transparent, broken, open_mid;
    logic [PEN_W-1:0] pen;
    logic             emit_old, emit_end;
    span_t            old_span, end_span;

    assign accept      = cells.valid && cells.ready;
    assign cells.ready = !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg      <= '0;
            dest_y_reg      <= '0;
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_width_reg  <= CLIP_SIZE_RST;
            clip_height_reg <= CLIP_SIZE_RST;
            tcode_reg       <= TRANSPARENT_NONE;
            pen_map_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DEST_X:      dest_x_reg      <= cfg_data[POS_W-1:0];
                CFG_DEST_Y:      dest_y_reg      <= cfg_data[POS_W-1:0];
                CFG_CLIP_LEFT:   clip_left_reg   <= cfg_data[POS_W-1:0];
                CFG_CLIP_TOP:    clip_top_reg    <= cfg_data[POS_W-1:0];
                CFG_CLIP_WIDTH:  clip_width_reg  <= cfg_data[POS_W-1:0];
                CFG_CLIP_HEIGHT: clip_height_reg <= cfg_data[POS_W-1:0];
                CFG_TRANSPARENT: tcode_reg       <= cfg_data[TCODE_W-1:0];
                CFG_PEN_MAP:     pen_map_reg     <= cfg_data;
            endcase
        end
    end

    // screen position and clip test, all edges at 9 bits
    assign sx      = {1'b0, dest_x_reg} + {2'b00, cells.cell_col};
    assign sy      = {1'b0, dest_y_reg} + {1'b0, cells.cell_row};
    assign clip_r  = {1'b0, clip_left_reg} + {1'b0, clip_width_reg};
    assign clip_b  = {1'b0, clip_top_reg} + {1'b0, clip_height_reg};
    assign visible = (sx >= {1'b0, clip_left_reg}) && (sx < clip_r)
                  && (sy >= {1'b0, clip_top_reg}) && (sy < clip_b)
                  && ({1'b0, cells.cell_col} < LEN_W'(MAX_WIDTH));

    // cell classification
    assign transparent = ({1'b0, cells.cell_code} == tcode_reg);
    assign pen = (cells.cell_code < PEN_MAPPED_LIMIT)
               ? pen_map_reg[{cells.cell_code[1:0], 2'b00} +: PEN_W]
               : cells.cell_code;
    assign broken = visible && run_open_reg
                 && ((cells.cell_row != run_row_reg)
                  || ({1'b0, cells.cell_col} != ({1'b0, run_start_reg} + run_len_reg)));
    assign open_mid = run_open_reg && !broken;

    // run update and emission flags
    always_comb
    begin
        run_open_next  = run_open_reg;
        run_start_next = run_start_reg;
        run_pen_next   = run_pen_reg;
        run_len_next   = run_len_reg;
        run_row_next   = run_row_reg;
        emit_old       = 1'b0;
        if (visible)
        begin
            if (broken)
            begin
                emit_old      = 1'b1;
                run_open_next = 1'b0;
            end
            if (transparent)
            begin
                if (open_mid)
                begin
                    emit_old      = 1'b1;
                    run_open_next = 1'b0;
                end
            end
            else if (open_mid && (pen == run_pen_reg))
            begin
                run_len_next = run_len_reg + 1'b1;
            end
            else
            begin
                if (open_mid)
                begin
                    emit_old = 1'b1;
                end
                run_open_next  = 1'b1;
                run_start_next = cells.cell_col;
                run_pen_next   = pen;
                run_len_next   = LEN_W'(1);
                run_row_next   = cells.cell_row;
            end
        end
        emit_end = cells.row_end && run_open_next;
        if (emit_end)
        begin
            run_open_next = 1'b0;
        end
    end

    // span records for the old run and the run left at row end
    always_comb
    begin
        old_span.x   = dest_x_reg + {1'b0, run_start_reg};
        old_span.y   = dest_y_reg + run_row_reg;
        old_span.len = run_len_reg;
        old_span.pen = run_pen_reg;
        end_span.x   = dest_x_reg + {1'b0, run_start_next};
        end_span.y   = dest_y_reg + run_row_next;
        end_span.len = run_len_next;
        end_span.pen = run_pen_next;
    end

    // queue request
    always_comb
    begin
        qwr.push    = accept && (emit_old || emit_end);
        qwr.ent.two = emit_old && emit_end;
        qwr.ent.s0  = emit_old ? old_span : end_span;
        qwr.ent.s1  = end_span;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_open_reg  <= 1'b0;
            run_start_reg <= '0;
            run_pen_reg   <= '0;
            run_len_reg   <= '0;
            run_row_reg   <= '0;
        end
        else if (accept)
        begin
            run_open_reg  <= run_open_next;
            run_start_reg <= run_start_next;
            run_pen_reg   <= run_pen_next;
            run_len_reg   <= run_len_next;
            run_row_reg   <= run_row_next;
        end
    end

endmodule

[design/ccrse_back.sv]
// back end: takes queue entries apart into single spans behind an output register
module ccrse_back
    import ccrse_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_nonempty,
    input  qent_t  q_head,
    output logic   q_pop,
    span_if.source spans
);

    logic  valid_reg, valid_next;
    logic  second_reg, second_next;
    logic  last_reg, last_next;
    span_t out_reg, out_next;
    logic  load, last_sel;

    assign load     = q_nonempty && (!valid_reg || spans.ready);
    assign last_sel = second_reg || !q_head.two;
    assign q_pop    = load && last_sel;

    // next output and position within the entry
    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        last_next   = last_reg;
        out_next    = out_reg;
        if (load)
        begin
            valid_next  = 1'b1;
            out_next    = second_reg ? q_head.s1 : q_head.s0;
            last_next   = last_sel;
            second_next = !last_sel;
        end
        else if (spans.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign spans.valid        = valid_reg;
    assign spans.span_x       = out_reg.x;
    assign spans.span_y       = out_reg.y;
    assign spans.span_len     = out_reg.len;
    assign spans.span_pen     = out_reg.pen;
    assign spans.last_of_item = last_reg;

endmodule

[design/clipped_cell_raster_span_emitter.sv]
// top level of the clipped cell raster span emitter
// throughput: one cell per cycle unless the queue is full; a cell's two spans go out in turn
// the span of a closing cell is written to the queue, then loaded into the output register
// the queue of QUEUE_DEPTH entries absorbs output stalls; cells wait only when it is full
// reset: asynchronous, active low; registers return to their reset values, no run open
module clipped_cell_raster_span_emitter
    import ccrse_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    cell_if.sink                  cells,
    span_if.source                spans
);

    qpush_t qwr;
    qent_t  q_head;
    logic   q_full, q_nonempty, q_pop;

    // classify cells and form spans
    ccrse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cells     (cells),
        .q_full    (q_full),
        .qwr       (qwr)
    );

    // decoupling queue
    ccrse_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (qwr),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    // emit spans one at a time
    ccrse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .spans      (spans)
    );

endmodule
